// ===== design/teba_pkg.sv =====
// Shared types and constants of the two-ended bump allocator.
// Used by teba_ctrl, teba_dp and two_ended_bump_allocator; depends on nothing.
package teba_pkg;

    localparam int SIZE_W      = 11;  // req_size, chunk size entries, threshold
    localparam int OFF_W       = 11;  // free_offset
    localparam int CHUNK_OFF_W = 10;  // chunk_offset result field
    localparam int STATUS_W    = 3;

    localparam int POOL_BYTES_DEF = 1024;
    localparam logic [SIZE_W-1:0] THRESH_RESET = 11'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_NOTSTART = 3'd4,
        ST_NOTALLOC = 3'd5
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the accepted input beat
        logic decide;  // latch the result and commit the operation if it passes
        logic emit;    // move the result into the output register
    } teba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_busy;  // bitmap walker still writing
        logic ok;         // operation under decision passes all checks
        logic out_free;   // output register can take a result this cycle
    } teba_sts_t;

endpackage

// ===== design/teba_ctrl.sv =====
// Sequencing state machine of the allocator.
// Depends on teba_pkg for the command and status structs.
module teba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  teba_pkg::teba_sts_t sts,
    output teba_pkg::teba_cmd_t cmd
);
    import teba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_WALK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;

    always_comb begin
        state_next  = state_reg;
        tready_next = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                if (!sts.walk_busy) begin
                    state_next  = S_IDLE;
                    tready_next = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid && tready_reg) begin
                    state_next = S_READ;
                end else begin
                    tready_next = 1'b1;
                end
            end
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = sts.ok ? S_WALK : S_EMIT;
            S_WALK: begin
                if (!sts.walk_busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    state_next  = S_IDLE;
                    tready_next = 1'b1;
                end
            end
            default: begin
                state_next  = S_IDLE;
                tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            tready_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

    assign s_tready   = tready_reg;
    assign cmd.load   = s_tvalid && tready_reg;
    assign cmd.decide = (state_reg == S_DECIDE);
    assign cmd.emit   = (state_reg == S_EMIT) && sts.out_free;

endmodule

// ===== design/teba_dp.sv =====
// Datapath: frontiers, used count, threshold, bitmap and size memories,
// range walker and output register. Depends on teba_pkg.
module teba_dp #(
    parameter int POOL_BYTES = teba_pkg::POOL_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [teba_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                             in_operation,
    input  logic [teba_pkg::SIZE_W-1:0]      in_req_size,
    input  logic [teba_pkg::OFF_W-1:0]       in_free_offset,
    input  teba_pkg::teba_cmd_t              cmd,
    output teba_pkg::teba_sts_t              sts,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [teba_pkg::STATUS_W-1:0]    out_status,
    output logic [teba_pkg::CHUNK_OFF_W-1:0] out_chunk_offset
);
    import teba_pkg::*;

    localparam int AW = $clog2(POOL_BYTES);
    localparam int CW = $clog2(POOL_BYTES + 1);
    localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int XW = LW + 1;
    localparam logic [XW-1:0] POOL_X    = XW'(POOL_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_BYTES - 1);

    logic [SIZE_W-1:0]      thr_reg;
    logic [AW-1:0]          front_reg, rear_reg;
    logic [CW-1:0]          used_reg;
    logic                   op_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [OFF_W-1:0]       off_reg;

    logic                   map_mem [POOL_BYTES];
    logic [SIZE_W-1:0]      size_mem [POOL_BYTES];
    logic                   map_rd_reg;
    logic [SIZE_W-1:0]      size_rd_reg;

    logic [AW-1:0]          walk_addr_reg;
    logic [LW-1:0]          walk_left_reg;
    logic                   walk_val_reg;
    logic                   walk_clr_reg;

    status_t                res_status_reg;
    logic [CHUNK_OFF_W-1:0] res_where_reg;
    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [CHUNK_OFF_W-1:0] out_where_reg;

    logic [XW-1:0] front_x, rear_x, used_x, req_x, off_x, sz_x, alloc_start_x;
    logic          alloc_large, free_small, walk_busy, commit;
    status_t       alloc_status, free_status, dec_status;
    logic [AW-1:0] rd_addr;
    logic          size_we;
    logic [AW-1:0] size_wa;
    logic [SIZE_W-1:0] size_wd;

    assign front_x = XW'(front_reg);
    assign rear_x  = XW'(rear_reg);
    assign used_x  = XW'(used_reg);
    assign req_x   = XW'(size_reg);
    assign off_x   = XW'(off_reg);
    assign sz_x    = XW'(size_rd_reg);
    assign rd_addr = AW'(off_reg);

    assign alloc_large   = (size_reg >= thr_reg);
    assign alloc_start_x = alloc_large ? (rear_x - req_x) : front_x;
    assign free_small    = (size_rd_reg < thr_reg);

    always_comb begin
        if (used_x >= POOL_X) begin
            alloc_status = ST_OOM;
        end else if (used_x + req_x > POOL_X) begin
            alloc_status = ST_NOSPACE;
        end else if (front_x + req_x >= rear_x) begin
            alloc_status = ST_NOSPACE;
        end else begin
            alloc_status = ST_OK;
        end
    end

    always_comb begin
        if (off_x >= POOL_X) begin
            free_status = ST_OUTSIDE;
        end else if (size_rd_reg == '0) begin
            free_status = ST_NOTSTART;
        end else if (!map_rd_reg) begin
            free_status = ST_NOTALLOC;
        end else begin
            free_status = ST_OK;
        end
    end

    assign dec_status = op_reg ? free_status : alloc_status;
    assign commit     = cmd.decide && (dec_status == ST_OK);
    assign walk_busy  = (walk_left_reg != '0);

    assign sts.walk_busy = walk_busy;
    assign sts.ok        = (dec_status == ST_OK);
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Size entry write: zero sweep after reset, else the commit of an operation.
    always_comb begin
        size_we = 1'b0;
        size_wa = walk_addr_reg;
        size_wd = '0;
        if (walk_busy && walk_clr_reg) begin
            size_we = 1'b1;
        end else if (commit) begin
            size_we = 1'b1;
            size_wa = op_reg ? rd_addr : AW'(alloc_start_x);
            size_wd = op_reg ? '0 : size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_wa] <= size_wd;
        end
        size_rd_reg <= size_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (walk_busy) begin
            map_mem[walk_addr_reg] <= walk_val_reg;
        end
        map_rd_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THRESH_RESET;
            front_reg     <= '0;
            rear_reg      <= LAST_ADDR;
            used_reg      <= '0;
            walk_addr_reg <= '0;
            walk_left_reg <= LW'(POOL_BYTES);
            walk_val_reg  <= 1'b0;
            walk_clr_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            // advance the walker; stop at the last pool byte
            if (walk_busy) begin
                if (walk_addr_reg == LAST_ADDR) begin
                    walk_left_reg <= '0;
                end else begin
                    walk_left_reg <= walk_left_reg - 1'b1;
                    walk_addr_reg <= walk_addr_reg + 1'b1;
                end
            end
            if (commit) begin
                walk_clr_reg <= 1'b0;
                if (!op_reg) begin
                    if (alloc_large) begin
                        rear_reg <= AW'(alloc_start_x);
                    end else begin
                        front_reg <= AW'(front_x + req_x);
                    end
                    used_reg      <= CW'(used_x + req_x);
                    walk_addr_reg <= AW'(alloc_start_x);
                    walk_left_reg <= LW'(size_reg);
                    walk_val_reg  <= 1'b1;
                end else begin
                    if (free_small) begin
                        if (off_x + sz_x == front_x) begin
                            front_reg <= AW'(front_x - sz_x);
                        end
                    end else if (off_x == rear_x) begin
                        rear_reg <= AW'(rear_x + sz_x);
                    end
                    used_reg      <= (used_x >= sz_x) ? CW'(used_x - sz_x) : '0;
                    walk_addr_reg <= rd_addr;
                    walk_left_reg <= LW'(size_rd_reg);
                    walk_val_reg  <= 1'b0;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_operation;
            size_reg <= in_req_size;
            off_reg  <= in_free_offset;
        end
        if (cmd.decide) begin
            res_status_reg <= dec_status;
            res_where_reg  <= (commit && !op_reg) ? CHUNK_OFF_W'(alloc_start_x) : '0;
        end
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_where_reg  <= res_where_reg;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_chunk_offset = out_where_reg;

endmodule

// ===== design/two_ended_bump_allocator.sv =====
// Top level of the two-ended bump allocator: controller plus datapath.
// Depends on teba_pkg, teba_ctrl and teba_dp.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  s_       | in        | s_tvalid / s_tready     | tuser: operation; tdata: req_size,
//           |           |                         |   free_offset
//  m_       | out       | m_tvalid / m_tready     | tdata: status, chunk_offset
//  cfg_     | in        | cfg_valid / cfg_ready   | cfg_data: large_threshold
//
// Cycles: one beat at a time. A passing allocate or free takes 5 + size cycles
// (accept, memory read, decide, one bitmap byte per cycle, one idle check, emit);
// a refused request takes 4. The single-bit bitmap write port sets the figure.
// Reset: after aresetn the bitmap and size memories are swept to zero, one
// entry per cycle, POOL_BYTES cycles; s_tready stays low meanwhile.
// Stalls: a held result sits in the output register; the next beat is accepted
// and worked up to its emit step while m_tready is low. cfg_ready is always high.
module two_ended_bump_allocator #(
    parameter int POOL_BYTES = teba_pkg::POOL_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] req_size, [21:11] free_offset, [23:22] zero
    input  logic        s_tuser,   // [0] operation (0 allocate, 1 free)
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] status, [12:3] chunk_offset, [15:13] zero
    // threshold write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [teba_pkg::SIZE_W-1:0] cfg_data
);
    import teba_pkg::*;

    teba_cmd_t              cmd;
    teba_sts_t              sts;
    logic [STATUS_W-1:0]    res_status;
    logic [CHUNK_OFF_W-1:0] res_chunk_offset;

    // threshold register takes a write on any cycle
    assign cfg_ready = 1'b1;

    teba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    teba_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .in_operation     (s_tuser),
        .in_req_size      (s_tdata[10:0]),
        .in_free_offset   (s_tdata[21:11]),
        .cmd              (cmd),
        .sts              (sts),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_status       (res_status),
        .out_chunk_offset (res_chunk_offset)
    );

    // pack status low, chunk offset above, zero fill to 16 bits
    assign m_tdata = {3'b000, res_chunk_offset, res_status};

`ifndef ASSERT_OFF
    // one beat at a time: after an accepted beat ready drops
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while another is in work");

    // never accept while the bitmap walker is still writing
    a_ready_walk_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.walk_busy)
        else $error("ready raised during a bitmap walk");

    // load, decide and emit are separate steps of the sequence
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.decide, cmd.emit}))
        else $error("overlapping controller commands");

    // emit only goes into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result emitted over a held beat");
`endif

endmodule
